// ===== hw/rtl/sccc_pkg.sv =====
// sccc_pkg: item types, request, bus and line state codes for the snooping cache
// controller; used by sccc_decide and the top level
`timescale 1ns / 1ps

package sccc_pkg;

    localparam logic [2:0] REQ_PRRD   = 3'd0;
    localparam logic [2:0] REQ_PRWR   = 3'd1;
    localparam logic [2:0] REQ_BUSRD  = 3'd2;
    localparam logic [2:0] REQ_BUSRDX = 3'd3;
    localparam logic [2:0] REQ_BUSUPG = 3'd4;

    localparam logic [2:0] BUS_NONE    = 3'd0;
    localparam logic [2:0] BUS_RD      = 3'd1;
    localparam logic [2:0] BUS_RDX     = 3'd2;
    localparam logic [2:0] BUS_UPGR    = 3'd3;
    localparam logic [2:0] BUS_UPD     = 3'd4;
    localparam logic [2:0] BUS_RD_UPD  = 3'd5;

    localparam logic [2:0] LS_I  = 3'd0;
    localparam logic [2:0] LS_S  = 3'd1;
    localparam logic [2:0] LS_E  = 3'd2;
    localparam logic [2:0] LS_M  = 3'd3;
    localparam logic [2:0] LS_SM = 3'd4;

    localparam logic [1:0] MODE_MSI    = 2'd0;
    localparam logic [1:0] MODE_MESI   = 2'd1;
    localparam logic [1:0] MODE_DRAGON = 2'd2;

    localparam int unsigned LS_W    = 3;
    localparam int unsigned STAMP_W = 32;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] address;
        logic        shared_line;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] bus_request;
        logic [2:0] new_state;
        logic       writeback;
        logic       flush;
        logic       intervention;
        logic       invalidation;
        logic       cache_to_cache;
        logic       memory_transaction;
    } out_item_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       shared_line;
        logic [1:0] mode;
        logic       found;
        logic [2:0] line_st;
        logic [2:0] victim_st;
    } dec_in_t;

endpackage

// ===== hw/rtl/sccc_decide.sv =====
// sccc_decide: coherence transition logic for MSI, MESI and Dragon
// depends on sccc_pkg
`timescale 1ns / 1ps

module sccc_decide
(
    input  sccc_pkg::dec_in_t   dec,
    output sccc_pkg::out_item_t res
);

    logic       wr;
    logic       mesi;
    logic       dragon;
    logic [2:0] st;

    always_comb
    begin
        res    = '0;
        wr     = (dec.req_type == sccc_pkg::REQ_PRWR);
        mesi   = (dec.mode == sccc_pkg::MODE_MESI);
        dragon = (dec.mode == sccc_pkg::MODE_DRAGON);
        st     = dec.line_st;
        case (dec.req_type) inside
            sccc_pkg::REQ_PRRD, sccc_pkg::REQ_PRWR:
            begin
                if (dec.found)
                begin
                    res.hit = 1'b1;
                    if (dragon)
                    begin
                        if (st == sccc_pkg::LS_E)
                        begin
                            if (wr)
                                st = sccc_pkg::LS_M;
                        end
                        else if (st == sccc_pkg::LS_S || st == sccc_pkg::LS_SM)
                        begin
                            if (wr)
                            begin
                                st = dec.shared_line ? sccc_pkg::LS_SM : sccc_pkg::LS_M;
                                res.bus_request = sccc_pkg::BUS_UPD;
                            end
                        end
                    end
                    else if (mesi)
                    begin
                        if (st == sccc_pkg::LS_S && wr)
                        begin
                            st = sccc_pkg::LS_M;
                            res.bus_request = sccc_pkg::BUS_UPGR;
                        end
                        else if (st == sccc_pkg::LS_E && wr)
                            st = sccc_pkg::LS_M;
                    end
                    else if (st == sccc_pkg::LS_S && wr)
                    begin
                        st = sccc_pkg::LS_M;
                        res.bus_request = sccc_pkg::BUS_RDX;
                        res.memory_transaction = 1'b1;
                    end
                end
                else
                begin
                    res.writeback = (dec.victim_st == sccc_pkg::LS_M) ||
                                    (dec.victim_st == sccc_pkg::LS_SM);
                    if (dragon)
                    begin
                        if (!wr)
                        begin
                            st = dec.shared_line ? sccc_pkg::LS_S : sccc_pkg::LS_E;
                            res.bus_request = sccc_pkg::BUS_RD;
                        end
                        else if (dec.shared_line)
                        begin
                            st = sccc_pkg::LS_SM;
                            res.bus_request = sccc_pkg::BUS_RD_UPD;
                        end
                        else
                        begin
                            st = sccc_pkg::LS_M;
                            res.bus_request = sccc_pkg::BUS_RD;
                        end
                    end
                    else if (mesi)
                    begin
                        res.cache_to_cache = dec.shared_line;
                        if (wr)
                        begin
                            st = sccc_pkg::LS_M;
                            res.bus_request = sccc_pkg::BUS_RDX;
                        end
                        else
                        begin
                            st = dec.shared_line ? sccc_pkg::LS_S : sccc_pkg::LS_E;
                            res.bus_request = sccc_pkg::BUS_RD;
                        end
                    end
                    else
                    begin
                        st = wr ? sccc_pkg::LS_M : sccc_pkg::LS_S;
                        res.bus_request = wr ? sccc_pkg::BUS_RDX : sccc_pkg::BUS_RD;
                    end
                end
                res.new_state = st;
            end
            sccc_pkg::REQ_BUSRD, sccc_pkg::REQ_BUSRDX, sccc_pkg::REQ_BUSUPG:
            begin
                if (dec.found)
                begin
                    res.hit = 1'b1;
                    if (dragon)
                    begin
                        if (st == sccc_pkg::LS_E && dec.req_type == sccc_pkg::REQ_BUSRD)
                        begin
                            st = sccc_pkg::LS_S;
                            res.intervention = 1'b1;
                        end
                        else if (st == sccc_pkg::LS_SM &&
                                 dec.req_type == sccc_pkg::REQ_BUSRD)
                            res.flush = 1'b1;
                        else if (st == sccc_pkg::LS_SM &&
                                 dec.req_type == sccc_pkg::REQ_BUSUPG)
                            st = sccc_pkg::LS_S;
                        else if (st == sccc_pkg::LS_M &&
                                 dec.req_type == sccc_pkg::REQ_BUSRD)
                        begin
                            st = sccc_pkg::LS_SM;
                            res.intervention = 1'b1;
                            res.flush = 1'b1;
                        end
                    end
                    else if (st == sccc_pkg::LS_M)
                    begin
                        if (dec.req_type == sccc_pkg::REQ_BUSRD)
                        begin
                            st = sccc_pkg::LS_S;
                            res.intervention = 1'b1;
                            res.writeback = 1'b1;
                            res.flush = 1'b1;
                        end
                        else if (dec.req_type == sccc_pkg::REQ_BUSRDX)
                        begin
                            st = sccc_pkg::LS_I;
                            res.invalidation = 1'b1;
                            res.writeback = 1'b1;
                            res.flush = 1'b1;
                        end
                    end
                    else if (st == sccc_pkg::LS_S)
                    begin
                        if (dec.req_type == sccc_pkg::REQ_BUSRDX ||
                            (mesi && dec.req_type == sccc_pkg::REQ_BUSUPG))
                        begin
                            st = sccc_pkg::LS_I;
                            res.invalidation = 1'b1;
                        end
                    end
                    else if (st == sccc_pkg::LS_E && mesi)
                    begin
                        if (dec.req_type == sccc_pkg::REQ_BUSRD)
                        begin
                            st = sccc_pkg::LS_S;
                            res.intervention = 1'b1;
                        end
                        else if (dec.req_type == sccc_pkg::REQ_BUSRDX)
                        begin
                            st = sccc_pkg::LS_I;
                            res.invalidation = 1'b1;
                        end
                    end
                    res.new_state = st;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/snooping_coherent_cache_controller_unit.sv =====
// snooping_coherent_cache_controller_unit: one item at a time: set read at accept, one way
// compared per cycle in the scan, then one row write-back with the result held in an output
// register; the update waits while that register is full and stalled; next item taken after it
// after reset a clearing pass invalidates every set before
// the first item is taken; configuration writes are taken at any time
// depends on sccc_pkg and sccc_decide
`timescale 1ns / 1ps

module snooping_coherent_cache_controller_unit
#(
    parameter int unsigned LINE_BYTES = 64,
    parameter int unsigned SET_COUNT  = 256,
    parameter int unsigned WAY_COUNT  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sccc_pkg::in_item_t   req_item,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sccc_pkg::out_item_t  rsp_item
);

    localparam int unsigned OFF_W   = $clog2(LINE_BYTES + 1) - 1;
    localparam int unsigned SET_W   = $clog2(SET_COUNT + 1) - 1;
    localparam int unsigned SETS    = 1 << SET_W;
    localparam int unsigned IDX_W   = (SET_W > 0) ? SET_W : 1;
    localparam int unsigned TAG_W   = 32 - OFF_W - SET_W;
    localparam int unsigned WAY_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int unsigned CNT_W   = $clog2(WAY_COUNT + 1);
    localparam int unsigned LS_W    = sccc_pkg::LS_W;
    localparam int unsigned STAMP_W = sccc_pkg::STAMP_W;
    localparam logic [31:0] SET_MASK = 32'((64'd1 << SET_W) - 64'd1);

    typedef enum logic [3:0]
    {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_UPDATE = 4'b1000
    } fsm_t;

    fsm_t                    state_reg, state_next;
    logic [1:0]              mode_reg;
    logic [STAMP_W-1:0]      counter_reg, counter_next;
    logic [IDX_W:0]          clr_reg, clr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    sccc_pkg::in_item_t      item_reg;
    logic [IDX_W-1:0]        set_reg;
    logic [TAG_W-1:0]        tag_reg;

    logic                    hf_reg, hf_next;
    logic [WAY_W-1:0]        hw_reg, hw_next;
    logic                    if_reg, if_next;
    logic [WAY_W-1:0]        iw_reg, iw_next;
    logic                    f1_reg, f1_next;
    logic [STAMP_W-1:0]      mn1_reg, mn1_next;
    logic [WAY_W-1:0]        v1_reg, v1_next;
    logic [STAMP_W-1:0]      mn2_reg, mn2_next;
    logic [WAY_W-1:0]        v2_reg, v2_next;

    logic                    out_valid_reg, out_valid_next;
    sccc_pkg::out_item_t     out_reg;

    logic [WAY_COUNT*(TAG_W+STAMP_W)-1:0] line_mem [SETS];
    logic [WAY_COUNT*LS_W-1:0]    coh_mem   [SETS];
    logic [WAY_COUNT*TAG_W-1:0]   tag_rd;
    logic [WAY_COUNT*LS_W-1:0]    coh_rd;
    logic [WAY_COUNT*STAMP_W-1:0] stamp_rd;
    logic [WAY_COUNT*TAG_W-1:0]   tag_wr;
    logic [WAY_COUNT*LS_W-1:0]    coh_wr;
    logic [WAY_COUNT*STAMP_W-1:0] stamp_wr;

    logic                    accept;
    logic                    load_out;
    logic [IDX_W-1:0]        in_set;
    logic [WAY_W-1:0]        way;
    logic [TAG_W-1:0]        way_tag;
    logic [LS_W-1:0]         way_st;
    logic [STAMP_W-1:0]      way_stamp;
    logic [WAY_W-1:0]        victim;
    logic [WAY_W-1:0]        sel_way;
    logic                    proc_req;
    sccc_pkg::dec_in_t       dec;
    sccc_pkg::out_item_t     dec_res;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign in_set    = IDX_W'((req_item.address >> OFF_W) & SET_MASK);
    assign way       = cnt_reg[WAY_W-1:0];
    assign way_tag   = tag_rd[way*TAG_W +: TAG_W];
    assign way_st    = coh_rd[way*LS_W +: LS_W];
    assign way_stamp = stamp_rd[way*STAMP_W +: STAMP_W];
    assign victim    = if_reg ? iw_reg : (f1_reg ? v1_reg : v2_reg);
    assign sel_way   = hf_reg ? hw_reg : victim;
    assign proc_req  = (item_reg.req_type == sccc_pkg::REQ_PRRD) ||
                       (item_reg.req_type == sccc_pkg::REQ_PRWR);
    assign load_out  = (state_reg == S_UPDATE) && (!out_valid_reg || !rsp_stall);

    assign dec.req_type    = item_reg.req_type;
    assign dec.shared_line = item_reg.shared_line;
    assign dec.mode        = mode_reg;
    assign dec.found       = hf_reg;
    assign dec.line_st     = coh_rd[hw_reg*LS_W +: LS_W];
    assign dec.victim_st   = coh_rd[victim*LS_W +: LS_W];

    sccc_decide u_decide
    (
        .dec (dec),
        .res (dec_res)
    );

    always_comb
    begin
        tag_wr   = tag_rd;
        coh_wr   = coh_rd;
        stamp_wr = stamp_rd;
        if (proc_req)
        begin
            tag_wr[sel_way*TAG_W +: TAG_W]         = tag_reg;
            stamp_wr[sel_way*STAMP_W +: STAMP_W]   = counter_reg;
            coh_wr[sel_way*LS_W +: LS_W]           = dec_res.new_state;
        end
        else if (dec_res.hit)
            coh_wr[hw_reg*LS_W +: LS_W] = dec_res.new_state;
    end

    // set memories: line states, and tags with stamps
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            coh_mem[clr_reg[IDX_W-1:0]] <= '0;
        else if (load_out)
        begin
            coh_mem[set_reg]  <= coh_wr;
            line_mem[set_reg] <= {tag_wr, stamp_wr};
        end
        if (accept)
        begin
            {tag_rd, stamp_rd} <= line_mem[in_set];
            coh_rd             <= coh_mem[in_set];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        counter_next   = counter_reg;
        hf_next        = hf_reg;
        hw_next        = hw_reg;
        if_next        = if_reg;
        iw_next        = iw_reg;
        f1_next        = f1_reg;
        mn1_next       = mn1_reg;
        v1_next        = v1_reg;
        mn2_next       = mn2_reg;
        v2_next        = v2_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (IDX_W+1)'(SETS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    counter_next = counter_reg + 1'b1;
                    cnt_next     = '0;
                    hf_next      = 1'b0;
                    if_next      = 1'b0;
                    f1_next      = 1'b0;
                    mn1_next     = counter_reg + 1'b1;
                    mn2_next     = '1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!hf_reg && way_st != sccc_pkg::LS_I && way_tag == tag_reg)
                begin
                    hf_next = 1'b1;
                    hw_next = way;
                end
                if (!if_reg && way_st == sccc_pkg::LS_I)
                begin
                    if_next = 1'b1;
                    iw_next = way;
                end
                if (way_stamp <= mn1_reg)
                begin
                    f1_next  = 1'b1;
                    mn1_next = way_stamp;
                    v1_next  = way;
                end
                if (way_stamp <= mn2_reg)
                begin
                    mn2_next = way_stamp;
                    v2_next  = way;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WAY_COUNT - 1))
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= sccc_pkg::MODE_MSI;
            counter_reg   <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            hf_reg        <= 1'b0;
            if_reg        <= 1'b0;
            f1_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
                mode_reg <= cfg_data;
            counter_reg   <= counter_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            hf_reg        <= hf_next;
            if_reg        <= if_next;
            f1_reg        <= f1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hw_reg  <= hw_next;
        iw_reg  <= iw_next;
        mn1_reg <= mn1_next;
        v1_reg  <= v1_next;
        mn2_reg <= mn2_next;
        v2_reg  <= v2_next;
        if (accept)
        begin
            item_reg <= req_item;
            set_reg  <= in_set;
            tag_reg  <= TAG_W'(req_item.address >> (OFF_W + SET_W));
        end
        if (load_out)
            out_reg <= dec_res;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

// ===== sim/snooping_coherent_cache_controller_unit_tb.sv =====
// snooping_coherent_cache_controller_unit_tb: self-checking bench for the snooping cache,
// a directed table then random traffic under MSI, MESI and Dragon, checked by a predictor
// depends on sccc_pkg and snooping_coherent_cache_controller_unit
`timescale 1ns / 1ps

module snooping_coherent_cache_controller_unit_tb;

    localparam int unsigned SETS = 256;
    localparam int unsigned WAYS = 8;
    localparam int unsigned OFF_BITS = 6;
    localparam int unsigned SET_BITS = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    sccc_pkg::in_item_t req_item;
    logic rsp_valid;
    logic rsp_stall;
    sccc_pkg::out_item_t rsp_item;

    snooping_coherent_cache_controller_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_item(req_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item)
    );

    // predictor state
    logic [17:0] tag_mem [SETS*WAYS];
    logic [2:0] state_mem [SETS*WAYS];
    logic [31:0] stamp_mem [SETS*WAYS];
    logic [31:0] stamp_now;
    logic [1:0] mode_now;

    sccc_pkg::out_item_t expected_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent;
    longint cycles = 0;
    int rx_wait = 0;
    logic rx_armed = 1'b0;

    typedef struct {
        logic [2:0] rq;
        logic [31:0] addr;
        logic sh;
        logic known;
        sccc_pkg::out_item_t res;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned choose_victim(int unsigned base);
        int unsigned v;
        logic [31:0] mn;
        logic got;
        v = 0;
        got = 1'b0;
        for (int w = 0; w < WAYS; w++)
            if (state_mem[base+w] == sccc_pkg::LS_I) return w;
        mn = stamp_now;
        for (int w = 0; w < WAYS; w++)
            if (stamp_mem[base+w] <= mn)
            begin
                v = w;
                mn = stamp_mem[base+w];
                got = 1'b1;
            end
        if (!got)
        begin
            mn = 32'hFFFF_FFFF;
            for (int w = 0; w < WAYS; w++)
                if (stamp_mem[base+w] <= mn)
                begin
                    v = w;
                    mn = stamp_mem[base+w];
                end
        end
        return v;
    endfunction

    function automatic sccc_pkg::out_item_t predict_access(logic [2:0] rq, logic [31:0] addr,
                                                           logic sh);
        sccc_pkg::out_item_t r;
        int unsigned base;
        int unsigned idx;
        logic [17:0] tg;
        logic [2:0] st;
        logic found;
        logic wr;
        logic mesi;
        logic dragon;
        r = '0;
        base = addr[OFF_BITS +: SET_BITS] * WAYS;
        tg = addr[31:OFF_BITS+SET_BITS];
        idx = 0;
        found = 1'b0;
        st = sccc_pkg::LS_I;
        mesi = (mode_now == sccc_pkg::MODE_MESI);
        dragon = (mode_now == sccc_pkg::MODE_DRAGON);
        stamp_now = stamp_now + 1;
        if (rq > sccc_pkg::REQ_BUSUPG) return r;
        for (int w = 0; w < WAYS; w++)
            if (!found && state_mem[base+w] != sccc_pkg::LS_I && tag_mem[base+w] == tg)
            begin
                idx = base + w;
                found = 1'b1;
            end
        if (rq == sccc_pkg::REQ_PRRD || rq == sccc_pkg::REQ_PRWR)
        begin
            wr = (rq == sccc_pkg::REQ_PRWR);
            if (found)
            begin
                r.hit = 1'b1;
                stamp_mem[idx] = stamp_now;
                st = state_mem[idx];
                if (dragon)
                begin
                    if (st == sccc_pkg::LS_E)
                    begin
                        if (wr) st = sccc_pkg::LS_M;
                    end
                    else if ((st == sccc_pkg::LS_S || st == sccc_pkg::LS_SM) && wr)
                    begin
                        st = sh ? sccc_pkg::LS_SM : sccc_pkg::LS_M;
                        r.bus_request = sccc_pkg::BUS_UPD;
                    end
                end
                else if (mesi)
                begin
                    if (st == sccc_pkg::LS_S && wr)
                    begin
                        st = sccc_pkg::LS_M;
                        r.bus_request = sccc_pkg::BUS_UPGR;
                    end
                    else if (st == sccc_pkg::LS_E && wr) st = sccc_pkg::LS_M;
                end
                else if (st == sccc_pkg::LS_S && wr)
                begin
                    st = sccc_pkg::LS_M;
                    r.bus_request = sccc_pkg::BUS_RDX;
                    r.memory_transaction = 1'b1;
                end
            end
            else
            begin
                idx = base + choose_victim(base);
                r.writeback = (state_mem[idx] == sccc_pkg::LS_M ||
                               state_mem[idx] == sccc_pkg::LS_SM);
                tag_mem[idx] = tg;
                stamp_mem[idx] = stamp_now;
                if (dragon)
                begin
                    if (!wr)
                    begin
                        st = sh ? sccc_pkg::LS_S : sccc_pkg::LS_E;
                        r.bus_request = sccc_pkg::BUS_RD;
                    end
                    else if (sh)
                    begin
                        st = sccc_pkg::LS_SM;
                        r.bus_request = sccc_pkg::BUS_RD_UPD;
                    end
                    else
                    begin
                        st = sccc_pkg::LS_M;
                        r.bus_request = sccc_pkg::BUS_RD;
                    end
                end
                else if (mesi)
                begin
                    st = wr ? sccc_pkg::LS_M : (sh ? sccc_pkg::LS_S : sccc_pkg::LS_E);
                    r.bus_request = wr ? sccc_pkg::BUS_RDX : sccc_pkg::BUS_RD;
                    r.cache_to_cache = sh;
                end
                else
                begin
                    st = wr ? sccc_pkg::LS_M : sccc_pkg::LS_S;
                    r.bus_request = wr ? sccc_pkg::BUS_RDX : sccc_pkg::BUS_RD;
                end
            end
            state_mem[idx] = st;
            r.new_state = st;
        end
        else if (found)
        begin
            r.hit = 1'b1;
            st = state_mem[idx];
            if (dragon)
            begin
                if (st == sccc_pkg::LS_E && rq == sccc_pkg::REQ_BUSRD)
                begin
                    st = sccc_pkg::LS_S;
                    r.intervention = 1'b1;
                end
                else if (st == sccc_pkg::LS_SM && rq == sccc_pkg::REQ_BUSRD) r.flush = 1'b1;
                else if (st == sccc_pkg::LS_SM && rq == sccc_pkg::REQ_BUSUPG)
                    st = sccc_pkg::LS_S;
                else if (st == sccc_pkg::LS_M && rq == sccc_pkg::REQ_BUSRD)
                begin
                    st = sccc_pkg::LS_SM;
                    r.intervention = 1'b1;
                    r.flush = 1'b1;
                end
            end
            else if (st == sccc_pkg::LS_M)
            begin
                if (rq == sccc_pkg::REQ_BUSRD)
                begin
                    st = sccc_pkg::LS_S;
                    r.intervention = 1'b1;
                    r.writeback = 1'b1;
                    r.flush = 1'b1;
                end
                else if (rq == sccc_pkg::REQ_BUSRDX)
                begin
                    st = sccc_pkg::LS_I;
                    r.invalidation = 1'b1;
                    r.writeback = 1'b1;
                    r.flush = 1'b1;
                end
            end
            else if (st == sccc_pkg::LS_S)
            begin
                if (rq == sccc_pkg::REQ_BUSRDX || (mesi && rq == sccc_pkg::REQ_BUSUPG))
                begin
                    st = sccc_pkg::LS_I;
                    r.invalidation = 1'b1;
                end
            end
            else if (st == sccc_pkg::LS_E && mesi)
            begin
                if (rq == sccc_pkg::REQ_BUSRD)
                begin
                    st = sccc_pkg::LS_S;
                    r.intervention = 1'b1;
                end
                else if (rq == sccc_pkg::REQ_BUSRDX)
                begin
                    st = sccc_pkg::LS_I;
                    r.invalidation = 1'b1;
                end
            end
            state_mem[idx] = st;
            r.new_state = st;
        end
        return r;
    endfunction

    task automatic send_item(logic [2:0] rq, logic [31:0] addr, logic sh, logic known,
                             sccc_pkg::out_item_t res);
        sccc_pkg::out_item_t p;
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 3) gap = 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        p = predict_access(rq, addr, sh);
        expected_q.push_back(known ? res : p);
        req_item <= '{req_type: rq, address: addr, shared_line: sh};
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_and_idle();
        req_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (WAYS + 6) @(negedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain_and_idle();
        cfg_write_en <= 1'b1;
        cfg_data <= m;
        mode_now = m;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [31:0] make_addr(int unsigned tg, int unsigned st);
        return {tg[17:0], st[7:0], 6'($urandom)};
    endfunction

    // receiver: holds rsp_stall for a randomly drawn wait on each result
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_armed = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rx_armed)
            begin
                rx_wait = $urandom_range(0, 3);
                rx_armed = 1'b1;
            end
            if (rsp_valid && rx_wait > 0)
            begin
                rsp_stall <= 1'b1;
                rx_wait--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_valid) rx_armed = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        sccc_pkg::out_item_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", rsp_item);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e != rsp_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected hit=%0d bus=%0d st=%0d wb=%0d fl=%0d",
                                 e.hit, e.bus_request, e.new_state, e.writeback, e.flush,
                                 " itv=%0d inv=%0d c2c=%0d mem=%0d",
                                 e.intervention, e.invalidation, e.cache_to_cache,
                                 e.memory_transaction);
                        $display("          got hit=%0d bus=%0d st=%0d wb=%0d fl=%0d",
                                 rsp_item.hit, rsp_item.bus_request, rsp_item.new_state,
                                 rsp_item.writeback, rsp_item.flush,
                                 " itv=%0d inv=%0d c2c=%0d mem=%0d",
                                 rsp_item.intervention, rsp_item.invalidation,
                                 rsp_item.cache_to_cache, rsp_item.memory_transaction);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t tbl[$];
        sccc_pkg::out_item_t z;
        sccc_pkg::out_item_t miss_rd;
        int unsigned base_tag;
        int unsigned hot_set;
        logic [2:0] rq;
        z = '0;
        miss_rd = '0;
        miss_rd.bus_request = sccc_pkg::BUS_RD;
        miss_rd.new_state = sccc_pkg::LS_S;
        items_sent = 0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req_item = '0;
        stamp_now = '0;
        mode_now = sccc_pkg::MODE_MSI;
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            state_mem[i] = sccc_pkg::LS_I;
            tag_mem[i] = '0;
            stamp_mem[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed table, msi after reset
        tbl.push_back('{sccc_pkg::REQ_BUSRD, 32'h0000_0000, 1'b0, 1'b1, z});
        tbl.push_back('{sccc_pkg::REQ_PRRD, 32'h0000_0000, 1'b0, 1'b1, miss_rd});
        tbl.push_back('{3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, z});
        tbl.push_back('{3'd5, 32'h1234_5678, 1'b0, 1'b1, z});
        tbl.push_back('{sccc_pkg::REQ_PRWR, 32'h0000_0000, 1'b0, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_BUSRD, 32'h0000_0010, 1'b0, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_BUSRDX, 32'h0000_0020, 1'b0, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_PRWR, 32'hFFFF_FFFF, 1'b1, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_BUSUPG, 32'hFFFF_FFC0, 1'b0, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_BUSRDX, 32'hFFFF_FFC0, 1'b1, 1'b0, z});
        // fill one set past its ways to force dirty evictions
        for (int i = 0; i < 10; i++)
            tbl.push_back('{sccc_pkg::REQ_PRWR, {18'(i + 5), 8'h3C, 6'h00}, 1'b0, 1'b0, z});
        tbl.push_back('{sccc_pkg::REQ_PRRD, {18'd5, 8'h3C, 6'h3F}, 1'b0, 1'b0, z});
        tbl.push_back('{3'd6, 32'h0, 1'b0, 1'b1, z});
        foreach (tbl[i]) send_item(tbl[i].rq, tbl[i].addr, tbl[i].sh, tbl[i].known,
                                   tbl[i].res);

        // random phases cycle through every mode, the unused code included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_mode(sccc_pkg::MODE_MESI);
                1: set_mode(sccc_pkg::MODE_DRAGON);
                2: set_mode(MODE_SPARE);
                default: set_mode(sccc_pkg::MODE_MSI);
            endcase
            hot_set = $urandom_range(0, SETS - 1);
            base_tag = $urandom_range(0, 18'h3FFF0);
            for (int n = 0; n < 210; n++)
            begin
                rq = 3'($urandom_range(0, 4));
                if ($urandom_range(0, 49) == 0) rq = 3'($urandom_range(5, 7));
                if ($urandom_range(0, 19) == 0)
                    send_item(rq, $urandom, 1'($urandom), 1'b0, z);
                else
                    send_item(rq, make_addr(base_tag + $urandom_range(0, 11),
                                            (hot_set + $urandom_range(0, 1)) % SETS),
                              1'($urandom), 1'b0, z);
                if (n == 100) drain_and_idle();
            end
        end
        drain_and_idle();
        $display("sent %0d items over MSI, MESI, Dragon and the spare mode code", items_sent);
        $display("%0d results checked, hot sets with evictions and snoops", results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/sccc_pkg.sv
hw/rtl/sccc_decide.sv
hw/rtl/snooping_coherent_cache_controller_unit.sv
sim/snooping_coherent_cache_controller_unit_tb.sv
